// ===== hdl/gdb_pkg.sv =====
// ============================================================================
// gdb_pkg: shared types and constants of the grid distance backtrace core
// Item codes, direction and neighbour codes, stream widths, and the command
// and status groups between the controller and the datapath.
// ============================================================================
package gdb_pkg;

    // Fixed widths of the item fields.
    localparam int COORD_W = 6;
    localparam int DIST_W = 14;

    // Stream data widths, rounded up to whole bytes.
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    // Item kinds carried in s_tuser.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Neighbour slots, visited in this order by every step that walks.
    localparam logic [1:0] SLOT_RIGHT = 2'd0;
    localparam logic [1:0] SLOT_LEFT = 2'd1;
    localparam logic [1:0] SLOT_YPLUS = 2'd2;
    localparam logic [1:0] SLOT_YMINUS = 2'd3;

    typedef enum logic [2:0] {
        DIR_NONE,
        DIR_RIGHT,
        DIR_LEFT,
        DIR_YPLUS,
        DIR_YMINUS
    } dir_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       accept;      // capture the input item
        logic       load_write;  // write the captured cell into the grid
        logic       step_begin;  // open a step, start the walk if needed
        logic       rd_en;       // read one neighbour from the grid
        logic [1:0] rd_slot;
        logic       ev_en;       // evaluate the neighbour read last cycle
        logic [1:0] ev_slot;
        logic       finish;      // emit the result and move
    } gdb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_step;
        logic walk_done;
        logic out_free;
    } gdb_stat_t;

endpackage

// ===== hdl/gdb_ctrl.sv =====
// ============================================================================
// gdb_ctrl: sequencing state machine
// Accepts one item at a time and steps the datapath through a load or
// through the four neighbour reads and compares of a backtrace step.
// ============================================================================
module gdb_ctrl
    import gdb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  gdb_stat_t stat,
    output gdb_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_EV3,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (!stat.is_step)
                begin
                    cmd.load_write = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (stat.walk_done)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.step_begin = 1'b1;
                    state_next = ST_RD0;
                end
            end
            ST_RD0:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_slot = SLOT_RIGHT;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_slot = SLOT_LEFT;
                cmd.ev_en = 1'b1;
                cmd.ev_slot = SLOT_RIGHT;
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_slot = SLOT_YPLUS;
                cmd.ev_en = 1'b1;
                cmd.ev_slot = SLOT_LEFT;
                state_next = ST_RD3;
            end
            ST_RD3:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_slot = SLOT_YMINUS;
                cmd.ev_en = 1'b1;
                cmd.ev_slot = SLOT_YPLUS;
                state_next = ST_EV3;
            end
            ST_EV3:
            begin
                cmd.ev_en = 1'b1;
                cmd.ev_slot = SLOT_YMINUS;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // Hold here until the output register can take the result.
                cmd.finish = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/gdb_datapath.sv =====
// ============================================================================
// gdb_datapath: grid memory, walk registers and output register
// Holds the distance grid in a single-port memory, the kept start cell,
// the walk position and best distance, and the registered result item.
// ============================================================================
module gdb_datapath
    import gdb_pkg::*;
#(
    parameter int GRID_WIDTH = 64,
    parameter int GRID_HEIGHT = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  gdb_cmd_t             cmd,
    output gdb_stat_t            stat,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int X_W = $clog2(GRID_WIDTH);
    localparam int Y_W = $clog2(GRID_HEIGHT);
    localparam int BEST_W = $clog2(CELL_COUNT + 1);

    // Captured input item.
    logic                item_cmd_reg;
    logic [COORD_W-1:0]  item_x_reg;
    logic [COORD_W-1:0]  item_y_reg;
    logic [DIST_W-1:0]   item_dist_reg;
    logic                item_start_reg;

    // Walk state.
    logic [X_W-1:0]      start_x_reg;
    logic [Y_W-1:0]      start_y_reg;
    logic                start_valid_reg;
    logic [X_W-1:0]      cur_x_reg;
    logic [Y_W-1:0]      cur_y_reg;
    logic [BEST_W-1:0]   best_reg;
    dir_t                dir_reg;
    logic                done_reg;
    logic                started_reg;
    logic                goal_reg;

    // Result item.
    logic                out_valid_reg;
    logic [COORD_W-1:0]  out_x_reg;
    logic [COORD_W-1:0]  out_y_reg;
    logic                out_start_reg;
    logic                out_last_reg;

    // Grid memory.
    logic [DIST_W-1:0]   grid_mem [CELL_COUNT];
    logic [DIST_W-1:0]   rd_data_reg;
    logic [ADDR_W-1:0]   mem_addr;
    logic                mem_we;

    logic [X_W-1:0]      load_x;
    logic [Y_W-1:0]      load_y;
    logic                load_inb;
    logic                start_newer;
    logic [ADDR_W-1:0]   load_addr;
    logic [X_W-1:0]      nb_x;
    logic [Y_W-1:0]      nb_y;
    logic [ADDR_W-1:0]   nb_addr;
    logic [3:0]          nb_inb;
    logic                ev_inb;
    logic                d_zero;
    logic                d_pos;
    logic [DIST_W-2:0]   d_mag;
    logic                d_better;
    dir_t                ev_dir;
    logic                here_start;

    // Load address and start-cell ordering; x-major order is lexicographic (x, y).
    always_comb
    begin
        load_x = X_W'(item_x_reg);
        load_y = Y_W'(item_y_reg);
        load_inb = (32'(item_x_reg) < GRID_WIDTH) && (32'(item_y_reg) < GRID_HEIGHT);
        load_addr = ADDR_W'(32'(load_x) * GRID_HEIGHT + 32'(load_y));
        start_newer = !start_valid_reg || (load_x > start_x_reg) ||
                      ((load_x == start_x_reg) && (load_y >= start_y_reg));
    end

    // Neighbour bounds, in slot order right, left, y+1, y-1.
    always_comb
    begin
        nb_inb[SLOT_RIGHT] = (32'(cur_x_reg) + 32'd1) < GRID_WIDTH;
        nb_inb[SLOT_LEFT] = cur_x_reg != '0;
        nb_inb[SLOT_YPLUS] = (32'(cur_y_reg) + 32'd1) < GRID_HEIGHT;
        nb_inb[SLOT_YMINUS] = cur_y_reg != '0;
    end

    // Neighbour coordinates for the read in progress.
    always_comb
    begin
        nb_x = cur_x_reg;
        nb_y = cur_y_reg;
        case (cmd.rd_slot)
            SLOT_RIGHT:  nb_x = cur_x_reg + X_W'(1);
            SLOT_LEFT:   nb_x = cur_x_reg - X_W'(1);
            SLOT_YPLUS:  nb_y = cur_y_reg + Y_W'(1);
            SLOT_YMINUS: nb_y = cur_y_reg - Y_W'(1);
            default:     nb_x = cur_x_reg;
        endcase
        nb_addr = ADDR_W'(32'(nb_x) * GRID_HEIGHT + 32'(nb_y));
    end

    assign mem_we = cmd.load_write && load_inb;
    assign mem_addr = cmd.load_write ? load_addr : nb_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_addr] <= item_dist_reg;
        end
        else if (cmd.rd_en)
        begin
            rd_data_reg <= grid_mem[mem_addr];
        end
    end

    // Compare of the neighbour read in the previous cycle.
    always_comb
    begin
        ev_inb = nb_inb[cmd.ev_slot];
        d_zero = rd_data_reg == '0;
        d_pos = !rd_data_reg[DIST_W-1] && !d_zero;
        d_mag = rd_data_reg[DIST_W-2:0];
        d_better = 32'(d_mag) < 32'(best_reg);
        case (cmd.ev_slot)
            SLOT_RIGHT:  ev_dir = DIR_RIGHT;
            SLOT_LEFT:   ev_dir = DIR_LEFT;
            SLOT_YPLUS:  ev_dir = DIR_YPLUS;
            SLOT_YMINUS: ev_dir = DIR_YMINUS;
            default:     ev_dir = DIR_NONE;
        endcase
        here_start = start_valid_reg && (cur_x_reg == start_x_reg) &&
                     (cur_y_reg == start_y_reg);
    end

    // Item capture and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_cmd_reg <= s_tuser;
            item_x_reg <= s_tdata[COORD_W-1:0];
            item_y_reg <= s_tdata[2*COORD_W-1:COORD_W];
            item_dist_reg <= s_tdata[2*COORD_W+DIST_W-1:2*COORD_W];
            item_start_reg <= s_tdata[2*COORD_W+DIST_W];
        end
        if (cmd.finish)
        begin
            out_x_reg <= COORD_W'(32'(cur_x_reg));
            out_y_reg <= COORD_W'(32'(cur_y_reg));
            out_start_reg <= here_start;
            out_last_reg <= goal_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            start_valid_reg <= 1'b0;
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            best_reg <= BEST_W'(CELL_COUNT);
            dir_reg <= DIR_NONE;
            done_reg <= 1'b0;
            started_reg <= 1'b0;
            goal_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                if (item_start_reg && start_newer)
                begin
                    start_x_reg <= load_x;
                    start_y_reg <= load_y;
                    start_valid_reg <= 1'b1;
                end
                best_reg <= BEST_W'(CELL_COUNT);
                dir_reg <= DIR_NONE;
                done_reg <= 1'b0;
                started_reg <= 1'b0;
            end

            if (cmd.step_begin)
            begin
                goal_reg <= 1'b0;
                if (!started_reg)
                begin
                    started_reg <= 1'b1;
                    cur_x_reg <= start_x_reg;
                    cur_y_reg <= start_y_reg;
                end
            end

            // A goal neighbour flags the step; later slots may still lower best.
            if (cmd.ev_en && ev_inb)
            begin
                if (d_zero)
                begin
                    goal_reg <= 1'b1;
                end
                else if (d_pos && d_better)
                begin
                    best_reg <= BEST_W'(d_mag);
                    dir_reg <= ev_dir;
                end
            end

            if (cmd.finish)
            begin
                case (dir_reg)
                    DIR_RIGHT:
                    begin
                        if (nb_inb[SLOT_RIGHT])
                        begin
                            cur_x_reg <= cur_x_reg + X_W'(1);
                        end
                    end
                    DIR_LEFT:
                    begin
                        if (nb_inb[SLOT_LEFT])
                        begin
                            cur_x_reg <= cur_x_reg - X_W'(1);
                        end
                    end
                    DIR_YPLUS:
                    begin
                        if (nb_inb[SLOT_YPLUS])
                        begin
                            cur_y_reg <= cur_y_reg + Y_W'(1);
                        end
                    end
                    DIR_YMINUS:
                    begin
                        if (nb_inb[SLOT_YMINUS])
                        begin
                            cur_y_reg <= cur_y_reg - Y_W'(1);
                        end
                    end
                    default:
                    begin
                        cur_x_reg <= cur_x_reg;
                    end
                endcase
                if (goal_reg)
                begin
                    done_reg <= 1'b1;
                end
            end

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.is_step = item_cmd_reg == CMD_STEP;
    assign stat.walk_done = done_reg;
    assign stat.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {{(M_TDATA_W - 2*COORD_W){1'b0}}, out_y_reg, out_x_reg};
    assign m_tuser = out_start_reg;
    assign m_tlast = out_last_reg;

endmodule

// ===== hdl/grid_distance_backtrace_core.sv =====
// ============================================================================
// grid_distance_backtrace_core: backtrace walk over a loaded distance grid
// Load items fill a grid of signed distances and mark start cells; step
// items walk from the kept start cell toward a goal cell one cell per item.
// ============================================================================
//
// Channel  Dir  Handshake          Payload
// s_*      in   tvalid/tready      tuser: kind (load or step)
//                                  tdata: cell_x, cell_y, cell_distance, cell_is_start
// m_*      out  tvalid/tready      tdata: path_x, path_y; tuser: at_start;
//                                  tlast: done_res (walk reached the goal)
//
// Items are taken one at a time. A load item is captured, then written once
// into the grid memory. A step item is captured and decoded, then makes four
// reads of the single-port grid memory, each compare in the cycle after its
// read, then a further state for the last compare and a final state that
// writes the output register and moves, waiting while the output is busy.
// A step taken after the walk has finished gives no result.
// Reset clears the walk and the start mark; the grid memory is not cleared,
// so every cell must be loaded before the walk reads it.
// A stalled output holds its item; the block finishes the next step only
// once the output register is free, and takes no new item meanwhile.
//
module grid_distance_backtrace_core
    import gdb_pkg::*;
#(
    parameter int GRID_WIDTH = 64,
    parameter int GRID_HEIGHT = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [5:0] cell_x, [11:6] cell_y, [25:12] cell_distance, [26] cell_is_start
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] cmd
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [5:0] path_x, [11:6] path_y
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] at_start
    output logic                 m_tuser,
    // done_res
    output logic                 m_tlast
);

    gdb_cmd_t  cmd;
    gdb_stat_t stat;

    // The controller owns sequencing; the datapath owns the grid and item storage.
    gdb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gdb_datapath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hdl/gdb_checker.sv =====
// ============================================================================
// gdb_checker: port-level checks of the backtrace core
// Watches the stream ports for handshake and item timing rules.
// ============================================================================
module gdb_checker
    import gdb_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser,
    input logic                 m_tlast
);

    // A stalled result item holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
            $stable(m_tuser) && $stable(m_tlast))
        else $error("result item changed while stalled");

    // Items are taken one at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken in the cycle after an accepted item");

    // A load item never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_LOAD) && !m_tvalid
            |=> !m_tvalid ##1 !m_tvalid)
        else $error("result appeared after a load item");

    // A step result needs the full memory read sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_STEP) && !m_tvalid
            |=> !m_tvalid ##5 !m_tvalid)
        else $error("step result appeared too early");

endmodule

bind grid_distance_backtrace_core gdb_checker u_gdb_checker (.*);
